[sv/lmsr_pkg.sv]
package lmsr_pkg;

   // command codes on req_cmd
   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // register indexes on csr_index
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_PANEL   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_HEIGHT = 1'd1;
   localparam int unsigned CSR_DATA_W  = 8;

   // fixed field widths
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned SCAN_ROW_W = 4;
   localparam int unsigned BYTE_BITS  = 8;

   // logical to physical row offset, and the widened y + offset operand
   localparam int unsigned ROW_OFFSET = 2;
   localparam int unsigned Y_EXT_W    = PIXEL_W + 1;
   localparam int unsigned MOD_CNT_W  = 4;

   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 8'd14;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_RD,
      ST_WR,
      ST_TICK
   } lmsr_state_type;

endpackage

[sv/led_matrix_scan_refresher.sv]
// Serial scan refresher for a multiplexed one-bit LED matrix. Commands enter on
// req_start while busy is low; results leave on rsp_strobe for exactly one cycle
// and the receiver cannot stall them, so it must take every strobe. Only a
// shift tick gives a result: the strobe comes the cycle after the transfer, as
// the frame store read is registered, and busy is high while the strobe is out,
// so a new tick is not taken in the strobe cycle. A pixel write keeps busy high
// through the bit-serial reduction of (y + 2) mod ROWS (one bit of y a cycle)
// followed by the read-modify-write of one frame byte. Clear, cmd 3 and ignored
// pixel writes finish in the transfer cycle and never raise busy. The frame
// store resets and clears through per-byte valid bits, so there is no clearing
// pass. Write csr registers only while busy is low.
module led_matrix_scan_refresher #(
   parameter int unsigned ROWS            = 14,
   parameter int unsigned COLS            = 80,
   parameter int unsigned NARROW_COLS     = 32,
   parameter int unsigned ROW_SELECT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_start,
   output logic                              busy,
   input  logic [lmsr_pkg::CMD_W-1:0]        req_cmd,
   input  logic [lmsr_pkg::PIXEL_W-1:0]      req_pixel_x,
   input  logic [lmsr_pkg::PIXEL_W-1:0]      req_pixel_y,
   input  logic                              req_pixel_on,
   output logic                              rsp_strobe,
   output logic                              rsp_data_bit,
   output logic                              rsp_latch_pulse,
   output logic [lmsr_pkg::SCAN_ROW_W-1:0]   rsp_scan_row,
   input  logic                              csr_wr_en,
   input  logic [lmsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lmsr_pkg::*;

   // geometry
   localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned ROW_BYTES = (COLS + BYTE_BITS - 1) / BYTE_BITS;
   localparam int unsigned BYTE_W    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int unsigned DEPTH     = ROWS * ROW_BYTES;
   localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned MAX_COLS  = (COLS > NARROW_COLS) ? COLS : NARROW_COLS;
   localparam int unsigned MAX_TOTAL = MAX_COLS + ROW_SELECT_BITS;
   localparam int unsigned BIT_W     = $clog2(MAX_TOTAL + 1);

   // control state
   lmsr_state_type   state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             wide_ff;
   logic [CSR_DATA_W-1:0] height_ff;

   // pixel write payload
   logic [PIXEL_W-1:0] x_ff, x_in;
   logic               on_ff, on_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   // tick result fields, captured at the transfer
   logic                  col_q_ff;
   logic                  sel_bit_ff;
   logic                  latch_ff;
   logic [2:0]            bsel_ff;
   logic [SCAN_ROW_W-1:0] srow_ff;

   // frame store and its valid bits
   logic [BYTE_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [BYTE_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   logic                 accept;
   logic                 pixel_ok;
   logic                 tick_accept;
   logic                 clear_go;
   logic                 mod_start;
   logic                 mod_done;
   logic [ROW_W-1:0]     mod_result;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 mem_we;
   logic [BYTE_BITS-1:0] old_byte;
   logic [BYTE_BITS-1:0] bit_mask;
   logic [BYTE_BITS-1:0] wr_byte;

   // scan position decode, all from registers
   logic [BIT_W-1:0]  colbits;
   logic [BIT_W-1:0]  total_m1;
   logic [BIT_W-1:0]  col;
   logic [BIT_W-1:0]  sel_k;
   logic              in_cols;
   logic              in_buf;
   logic              sel_bit;
   logic              latch;
   logic [ADDR_W-1:0] tick_addr;

   assign accept      = req_start && !busy;
   assign pixel_ok    = (req_pixel_x < PIXEL_W'(COLS)) && (req_pixel_y < height_ff);
   assign tick_accept = accept && (req_cmd == CMD_TICK);
   assign clear_go    = accept && (req_cmd == CMD_CLEAR);

   assign colbits  = wide_ff ? BIT_W'(COLS) : BIT_W'(NARROW_COLS);
   assign total_m1 = colbits + BIT_W'(ROW_SELECT_BITS - 1);
   assign in_cols  = bit_ff < colbits;
   // columns go out from the highest one down
   assign col      = colbits - BIT_W'(1) - bit_ff;
   // narrow width wider than the buffer sends zeros above it
   assign in_buf   = in_cols && (col < BIT_W'(COLS));
   assign sel_k    = bit_ff - colbits;
   // row-select bits, msb first, one-hot on the current row
   assign sel_bit  = !in_cols && (sel_k < BIT_W'(ROW_SELECT_BITS)) &&
                     ((BIT_W'(ROW_SELECT_BITS - 1) - sel_k) == BIT_W'(row_ff));
   // at or past the last bit also covers a width switch in mid-row
   assign latch    = bit_ff >= total_m1;
   assign tick_addr = in_buf ?
      (ADDR_W'(row_ff) * ADDR_W'(ROW_BYTES) + ADDR_W'(BYTE_W'(col >> 3))) : '0;

   // (y + 2) mod ROWS, one bit of y per cycle
   lmsr_mod_unit #(
      .ROWS(ROWS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (Y_EXT_W'(req_pixel_y) + Y_EXT_W'(ROW_OFFSET)),
      .done  (mod_done),
      .result(mod_result)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      bit_in    = bit_ff;
      x_in      = x_ff;
      on_in     = on_ff;
      addr_in   = addr_ff;
      mod_start = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = tick_addr;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_PIXEL) && pixel_ok) begin
               x_in      = req_pixel_x;
               on_in     = req_pixel_on;
               mod_start = 1'b1;
               state_in  = ST_MOD;
            end else if (tick_accept) begin
               rd_en    = 1'b1;
               state_in = ST_TICK;
               // scan position moves on at the transfer
               if (latch) begin
                  bit_in = '0;
                  row_in = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               addr_in  = ADDR_W'(mod_result) * ADDR_W'(ROW_BYTES) +
                          ADDR_W'(BYTE_W'(x_ff >> 3));
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = addr_ff;
            state_in = ST_WR;
         end
         ST_WR: begin
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         row_ff    <= '0;
         bit_ff    <= '0;
         wide_ff   <= 1'b1;
         height_ff <= HEIGHT_RESET;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         bit_ff   <= bit_in;
         if (csr_wr_en && (csr_index == CSR_WIDE_PANEL)) begin
            wide_ff <= csr_wdata[0];
         end
         if (csr_wr_en && (csr_index == CSR_PANEL_HEIGHT)) begin
            height_ff <= csr_wdata;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      on_ff   <= on_in;
      addr_ff <= addr_in;
      if (tick_accept) begin
         col_q_ff   <= in_buf;
         sel_bit_ff <= sel_bit;
         latch_ff   <= latch;
         bsel_ff    <= col[2:0];
         srow_ff    <= SCAN_ROW_W'(row_ff);
      end
   end

   // read-modify-write of one frame byte
   assign old_byte = rd_valid_ff ? rd_data_ff : '0;
   assign bit_mask = BYTE_BITS'(1) << x_ff[2:0];
   assign wr_byte  = on_ff ? (old_byte | bit_mask) : (old_byte & ~bit_mask);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wr_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // an entry not valid reads as zero; clear drops them all at once
   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[addr_ff] <= 1'b1;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_TICK);
   assign rsp_data_bit    = col_q_ff ? (rd_valid_ff & rd_data_ff[bsel_ff]) : sel_bit_ff;
   assign rsp_latch_pulse = latch_ff;
   assign rsp_scan_row    = srow_ff;

   a_strobe_after_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_start && !busy && (req_cmd == CMD_TICK)))
      else $error("result strobe without a tick transfer");

   a_latch_restarts_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_latch_pulse) |-> (bit_ff == '0))
      else $error("latch did not restart the row");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, row_ff} < (ROW_W + 1)'(ROWS)))
      else $error("scan row out of range");

   a_mod_done_expected: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("row reduction finished outside a pixel write");

endmodule

[sv/lmsr_mod_unit.sv]
module lmsr_mod_unit #(
   parameter int unsigned ROWS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lmsr_pkg::Y_EXT_W-1:0]  value,
   output logic                          done,
   output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] result
);
   import lmsr_pkg::*;

   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned REM_W = ROW_W + 1;

   logic [Y_EXT_W-1:0]   val_ff, val_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [REM_W-1:0]     trial;

   // one dividend bit per cycle, msb first: rem = 2*rem + bit, reduce once
   assign trial = {rem_ff[ROW_W-1:0], val_ff[Y_EXT_W-1]};

   always_comb begin
      val_in    = val_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         val_in    = value;
         rem_in    = '0;
         cnt_in    = MOD_CNT_W'(Y_EXT_W);
         active_in = 1'b1;
      end else if (active_ff) begin
         val_in = {val_ff[Y_EXT_W-2:0], 1'b0};
         rem_in = (trial >= REM_W'(ROWS)) ? (trial - REM_W'(ROWS)) : trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MOD_CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = rem_ff[ROW_W-1:0];

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (rem_ff < REM_W'(ROWS)))
      else $error("row remainder out of range");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff)
      else $error("row reduction restarted while running");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done |-> !active_ff)
      else $error("row reduction still running when done");

endmodule
